@@ design/ncdf_pkg.sv @@
// shared constants, types and rounding helper for the normal cdf pipeline
// no dependencies
`default_nettype none

package ncdf_pkg;

	localparam int DIV_STEPS = 31;
	localparam int HORNER_STEPS = 5;
	localparam int EXP_TERMS = 12;
	localparam int EXP_SQUARES = 4;

	localparam logic [31:0] ONE_Q30 = 32'd1073741824;
	localparam logic [31:0] HALF_Q30 = 32'd536870912;
	localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
	localparam logic [28:0] P_Q30 = 29'd351748265;
	localparam logic signed [31:0] A5_Q30 = 32'sd1139675401;

	// added after each horner multiply, last step adds nothing
	localparam logic signed [31:0] HORNER_ADD [HORNER_STEPS] = '{
		-32'sd1560310108, 32'sd1526231383, -32'sd305476044, 32'sd273621191, 32'sd0
	};

	// reciprocal multipliers for the series divisors, index is the divisor
	localparam logic [31:0] RECIP [1:EXP_TERMS] = '{
		32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
		32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
		32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531
	};
	localparam logic [5:0] RSHIFT [1:EXP_TERMS] = '{
		6'd31, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34,
		6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd35
	};

	typedef struct packed {
		logic        neg;
		logic        huge;
		logic [30:0] f;
	} side_t;

	// shift right by 30, halves rounded away from zero
	function automatic logic signed [33:0] shr_round30(input logic signed [63:0] v);
		logic [63:0] m;
		logic [33:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = 34'((m + 64'(HALF_Q30)) >> 30);
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

endpackage

`default_nettype wire

@@ design/normal_cdf_approximation.sv @@
// Standard normal CDF of a signed Q4.12 argument, result unsigned Q0.16 saturating at
// 65535. Fully pipelined: one request enters every cycle and one result leaves every
// cycle while the output is not stalled. The pipeline has three front stages, the
// 31-stage quotient divider for t, the five Horner stages, 24 series stages and four
// squaring stages of the exponential, and two final stages. All stages advance together;
// a stalled result holds the whole pipeline.
// depends on ncdf_pkg and ncdf_div
`default_nettype none

module normal_cdf_approximation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        cdf_value
);
	import ncdf_pkg::*;

	localparam int EXP_STAGES = 2 * EXP_TERMS + EXP_SQUARES;

	typedef struct packed {
		side_t              side;
		logic [30:0]        t;
		logic signed [31:0] acc;
	} hor_t;

	typedef struct packed {
		logic               neg;
		logic               huge;
		logic [30:0]        f;
		logic signed [31:0] acc;
		logic [30:0]        val;
	} exp_t;

	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// magnitude
	logic        v_s1, neg_s1;
	logic [15:0] mag_s1;
	// z = a / sqrt2
	logic        v_s2, neg_s2, huge_s2;
	logic [31:0] z_s2;
	logic [46:0] zf;
	// denominator and z^2/16
	logic        v_s3;
	logic [31:0] den_s3;
	side_t       side_s3;
	logic [61:0] pzp;
	logic [63:0] sq;
	logic [31:0] fr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign zf = 47'(mag_s1) * 47'(INV_SQRT2_Q30) + 47'd2048;
	assign pzp = 62'(z_s2) * 62'(P_Q30) + 62'(HALF_Q30);
	assign sq = 64'(z_s2) * 64'(z_s2);
	assign fr = ({1'b0, sq[63:33]} + 32'd1) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= x_value[15];
			mag_s1 <= x_value[15] ? 16'($unsigned(-x_value)) : 16'($unsigned(x_value));
			neg_s2 <= neg_s1;
			huge_s2 <= |zf[46:44];
			z_s2 <= zf[43:12];
			den_s3 <= 32'(ONE_Q30 + pzp[61:30]);
			side_s3 <= '{neg: neg_s2, huge: huge_s2, f: fr[30:0]};
		end
	end

	logic        v_d;
	logic [30:0] t_d;
	side_t       side_d;

	ncdf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.den      (den_s3),
		.side_in  (side_s3),
		.out_valid(v_d),
		.quo      (t_d),
		.side_out (side_d)
	);

	// horner chain
	hor_t hor_s [HORNER_STEPS];
	hor_t hor_n [HORNER_STEPS];
	logic [HORNER_STEPS-1:0] hor_v;

	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_hor
		hor_t prev;
		logic signed [31:0] acc_in;
		logic signed [63:0] p;
		logic signed [33:0] pr;
		if (j == 0) begin : g_head
			assign prev = '{side: side_d, t: t_d, acc: A5_Q30};
		end else begin : g_body
			assign prev = hor_s[j-1];
		end
		assign acc_in = prev.acc;
		assign p = acc_in * $signed({1'b0, prev.t});
		assign pr = shr_round30(p);
		always_comb begin
			hor_n[j] = prev;
			hor_n[j].acc = pr[31:0] + HORNER_ADD[j];
		end
	end

	// exp(-z^2/16) series then four squarings
	exp_t exp_s [EXP_STAGES];
	exp_t exp_n [EXP_STAGES];
	logic [EXP_STAGES-1:0] exp_v;

	for (genvar j = 0; j < EXP_STAGES; j++) begin : g_exp
		exp_t prev;
		logic [30:0] s_in;
		if (j == 0) begin : g_head
			assign prev = '{neg: hor_s[HORNER_STEPS-1].side.neg,
				huge: hor_s[HORNER_STEPS-1].side.huge,
				f: hor_s[HORNER_STEPS-1].side.f,
				acc: hor_s[HORNER_STEPS-1].acc, val: ONE_Q30[30:0]};
			assign s_in = ONE_Q30[30:0];
		end else begin : g_body
			assign prev = exp_s[j-1];
			assign s_in = (exp_s[j-1].val >= ONE_Q30[30:0]) ? 31'd0
				: 31'(ONE_Q30 - 32'(exp_s[j-1].val));
		end
		if (j < 2 * EXP_TERMS && j % 2 == 0) begin : g_mul
			logic [61:0] mp;
			assign mp = 62'(prev.f) * 62'(s_in) + 62'(HALF_Q30);
			always_comb begin
				exp_n[j] = prev;
				exp_n[j].val = mp[60:30];
			end
		end else if (j < 2 * EXP_TERMS) begin : g_div
			localparam int K = EXP_TERMS - j / 2;
			logic [31:0] n;
			logic [63:0] dp;
			assign n = 32'(prev.val) + 32'(K / 2);
			assign dp = 64'(n) * 64'(RECIP[K]);
			always_comb begin
				exp_n[j] = prev;
				exp_n[j].val = 31'(dp >> RSHIFT[K]);
			end
		end else begin : g_sq
			logic [30:0] s_sq;
			logic [61:0] qp;
			if (j == 2 * EXP_TERMS) begin : g_first
				assign s_sq = s_in;
			end else begin : g_next
				assign s_sq = prev.val;
			end
			assign qp = 62'(s_sq) * 62'(s_sq) + 62'(HALF_Q30);
			always_comb begin
				exp_n[j] = prev;
				exp_n[j].val = qp[60:30];
			end
		end
	end

	// product and y
	logic        v_p, neg_p;
	logic [30:0] y_p;
	logic [30:0] e_val;
	logic signed [63:0] ep;
	logic signed [33:0] epr;
	logic [30:0] y_n;
	exp_t        exp_last;

	assign exp_last = exp_s[EXP_STAGES-1];
	assign e_val = exp_last.huge ? 31'd0 : exp_last.val;
	assign ep = exp_last.acc * $signed({1'b0, e_val});
	assign epr = shr_round30(ep);

	always_comb begin
		priority if (epr < 0) begin
			y_n = ONE_Q30[30:0];
		end else if (epr > $signed({2'b00, ONE_Q30})) begin
			y_n = 31'd0;
		end else begin
			y_n = 31'(ONE_Q30 - epr[31:0]);
		end
	end

	logic [31:0] r;
	logic [31:0] qr;
	assign r = neg_p ? 32'(ONE_Q30 - 32'(y_p)) : 32'(ONE_Q30 + 32'(y_p));
	assign qr = (r + 32'd16384) >> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hor_v <= '0;
			exp_v <= '0;
			v_p <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			hor_v <= {hor_v[HORNER_STEPS-2:0], v_d};
			exp_v <= {exp_v[EXP_STAGES-2:0], hor_v[HORNER_STEPS-1]};
			v_p <= exp_v[EXP_STAGES-1];
			out_valid <= v_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hor_s <= hor_n;
			exp_s <= exp_n;
			neg_p <= exp_last.neg;
			y_p <= y_n;
			cdf_value <= (qr > 32'd65535) ? 16'hFFFF : qr[15:0];
		end
	end

`ifndef ASSERT_OFF
	a_hold_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(exp_v) && $stable(hor_v) && out_valid)
		else $error("pipeline moved while stalled");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_d |-> t_d <= ONE_Q30[30:0])
		else $error("reciprocal above one");
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_p |-> y_p <= ONE_Q30[30:0])
		else $error("y above one");
	a_huge_full: assert property (@(posedge clk) disable iff (!arst_n)
		(en && exp_v[EXP_STAGES-1] && exp_last.huge) |=> y_p == ONE_Q30[30:0])
		else $error("large argument not saturated");
`endif

endmodule

`default_nettype wire

@@ design/ncdf_div.sv @@
// pipelined restoring divider, one quotient bit per stage, forms 2^60 / den rounded
// depends on ncdf_pkg
`default_nettype none

module ncdf_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [31:0]          den,
	input  ncdf_pkg::side_t      side_in,
	output logic                 out_valid,
	output logic [30:0]          quo,
	output ncdf_pkg::side_t      side_out
);
	import ncdf_pkg::*;

	typedef struct packed {
		logic [31:0]          den;
		logic [31:0]          rem;
		logic [DIV_STEPS-1:0] quo;
		side_t                side;
	} div_stage_t;

	div_stage_t step_s [DIV_STEPS];
	div_stage_t next_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] valid_s;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		div_stage_t prev;
		logic [32:0] cand;
		logic ge;
		if (j == 0) begin : g_head
			// numerator is 2^60 + den/2, its top part is 2^29
			assign prev = '{den: den, rem: HALF_Q30, quo: '0, side: side_in};
		end else begin : g_body
			assign prev = step_s[j-1];
		end
		assign cand = {prev.rem, prev.den[DIV_STEPS-j]};
		assign ge = cand >= {1'b0, prev.den};
		always_comb begin
			next_s[j] = prev;
			next_s[j].rem = ge ? 32'(cand - {1'b0, prev.den}) : cand[31:0];
			next_s[j].quo = {prev.quo[DIV_STEPS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DIV_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s <= next_s;
		end
	end

	assign out_valid = valid_s[DIV_STEPS-1];
	assign quo = step_s[DIV_STEPS-1].quo;
	assign side_out = step_s[DIV_STEPS-1].side;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for normal_cdf_approximation: directed and random requests, bit-exact
// prediction of each cdf result, random gaps and stalls on both channels
// depends on the block under test only
`default_nettype none

module tb_top;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] x_value;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        cdf_value;

	logic [15:0] cdf_expected [$];
	int          mismatches;
	int          idle_cycles;
	bit          hold_long;
	bit          stall_quiet;

	localparam longint ONE = 64'd1073741824;
	localparam int     IDLE_LIMIT = 20000;

	normal_cdf_approximation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .x_value(x_value),
		.out_valid(out_valid), .out_stall(out_stall), .cdf_value(cdf_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint rnd_shift(input longint v, input int n);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (n - 1))) >>> n;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint exp_neg_square(input longint z);
		longint unsigned sq, f, s, m, d;
		sq = z * z;
		f = ((sq >> 33) + 1) >> 1;
		s = ONE;
		for (int k = 12; k >= 1; k--) begin
			m = (f * s + (64'd1 << 29)) >> 30;
			d = (m + k / 2) / k;
			s = (d >= ONE) ? 0 : ONE - d;
		end
		for (int k = 0; k < 4; k++)
			s = (s * s + (64'd1 << 29)) >> 30;
		return longint'(s);
	endfunction

	function automatic logic [15:0] normal_cdf(input logic [15:0] raw);
		logic neg;
		longint unsigned a, z, pz, den, q;
		longint t, acc, e, prod, y, r;
		neg = raw[15];
		a = neg ? 65536 - raw : raw;
		z = (a * 64'd759250125 + (64'd1 << 11)) >> 12;
		pz = (z * 64'd351748265 + (64'd1 << 29)) >> 30;
		den = ONE + pz;
		t = longint'(((64'd1 << 60) + den / 2) / den);
		acc = 64'sd1139675401;
		acc = rnd_shift(acc * t, 30) - 64'sd1560310108;
		acc = rnd_shift(acc * t, 30) + 64'sd1526231383;
		acc = rnd_shift(acc * t, 30) - 64'sd305476044;
		acc = rnd_shift(acc * t, 30) + 64'sd273621191;
		acc = rnd_shift(acc * t, 30);
		e = (z >= (64'd4 << 30)) ? 0 : exp_neg_square(z);
		prod = rnd_shift(acc * e, 30);
		if (prod < 0) prod = 0;
		y = ONE - prod;
		if (y < 0) y = 0;
		if (y > ONE) y = ONE;
		r = neg ? ONE - y : ONE + y;
		q = (longint'(r) + (64'd1 << 14)) >> 15;
		if (q > 65535) q = 65535;
		return q[15:0];
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	task automatic send_request(input logic [15:0] x, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= x;
		cdf_expected.insert(cdf_expected.size(), normal_cdf(x));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (cdf_expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [15:0] vals [$];
		vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
			16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h5A82, 16'hA57E,
			16'h5A83, 16'hA57D, 16'h0800, 16'hF800, 16'h4000, 16'hC000,
			16'h5555, 16'hAAAA, 16'h0100, 16'hFF00};
		foreach (vals[i]) send_request(vals[i], 1'b0);
		wait_drained();
	endtask

	task automatic test_random(input int n);
		logic [15:0] x;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: x = 16'($urandom);
				1: x = 16'($signed($urandom_range(0, 8191)) - 4096);
				2: x = 16'($signed($urandom_range(0, 47000)) - 23500);
				default: x = $urandom_range(0, 1) ? 16'(16'h8000 + $urandom_range(0, 600))
					: 16'(16'h7FFF - $urandom_range(0, 600));
			endcase
			send_request(x, (i % 300) > 40);
		end
	endtask

	task automatic test_backpressure();
		hold_long = 1'b1;
		for (int i = 0; i < 250; i++) send_request(16'($urandom), 1'b0);
		hold_long = 1'b0;
		wait_drained();
	endtask

	// receiver side
	initial begin
		int g;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				do @(posedge clk); while (hold_long);
			end else if (stall_quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				g = gap_len();
				out_stall <= (g != 0);
				repeat (g == 0 ? $urandom_range(1, 8) : g) @(posedge clk);
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		logic [15:0] e;
		if (arst_n && out_valid && !out_stall) begin
			if (cdf_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d", cdf_value);
			end else begin
				e = cdf_expected.pop_front();
				if (e !== cdf_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cdf mismatch: expected %0d actual %0d", e, cdf_value);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		hold_long = 1'b0;
		stall_quiet = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		x_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1700);
		wait_drained();
		if (mismatches == 0 && cdf_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ normal_cdf_approximation.f @@
design/ncdf_pkg.sv
design/ncdf_div.sv
design/normal_cdf_approximation.sv
dv/tb_top.sv
